/* sv/nes7_pkg.sv */
package nes7_pkg;

  localparam int unsigned IO_W = 25;

  localparam logic [1:0] DIV2 = 2'd0;
  localparam logic [1:0] DIV3 = 2'd1;
  localparam logic [1:0] DIV5 = 2'd2;
  localparam logic [1:0] DIV7 = 2'd3;

  localparam logic [31:0] INV3 = 32'hAAAA_AAAB;
  localparam logic [31:0] INV5 = 32'hCCCC_CCCD;
  localparam logic [31:0] INV7 = 32'hB6DB_6DB7;

  typedef struct packed {
    logic load;
    logic step;
    logic next;
    logic finish;
  } nes7_cmd_t;

  typedef struct packed {
    logic smooth;
    logic fail;
  } nes7_status_t;

endpackage

/* sv/next_even_7_smooth_number.sv */
// next_even_7_smooth_number
// returns the smallest even number at or above a request whose only prime
// factors are 2, 3, 5 and 7; a request of 0 returns 0, one above 2**WIDTH returns 2**WIDTH
// input: request_size is taken on a rising edge with start high and busy low
// output: chosen_size is valid for exactly one cycle while done is high; the
// receiver cannot stall, so every result is a transfer in that cycle
// busy stays high from the cycle after the transfer in until done rises;
// a new request may be given in the same cycle that done is high
// search: candidates step by 2 from the request; each candidate costs
// one trial per prime factor removed plus one per divisor ruled out (at most
// 4 failed trials per candidate)
// the search is set by the single trial-division unit in the datapath, one
// exact division by 2, 3, 5 or 7 per cycle; one request is worked at a time,
// so a new one is taken only once the last result is out
// reset: synchronous, returns the controller to idle with no strobe pending
module next_even_7_smooth_number #(
  parameter int unsigned WIDTH = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [nes7_pkg::IO_W-1:0] request_size,
  output logic                      done,
  output logic [nes7_pkg::IO_W-1:0] chosen_size
);
  import nes7_pkg::*;

  nes7_cmd_t    cmd;
  nes7_status_t status;

  nes7_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  nes7_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .request_size (request_size),
    .status       (status),
    .chosen_size  (chosen_size)
  );

endmodule

/* sv/nes7_ctrl.sv */
module nes7_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  nes7_pkg::nes7_status_t status,
  output nes7_pkg::nes7_cmd_t   cmd,
  output logic                  busy,
  output logic                  done
);
  import nes7_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state;
  logic state_next;
  logic done_next;

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (status.smooth) begin
          cmd.finish = 1'b1;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if (status.fail) begin
          cmd.next = 1'b1;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state == S_RUN);

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.next, cmd.finish}))
    else $error("more than one datapath command");

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == S_RUN) && (state == S_IDLE))
    else $error("result strobe without a finished search");

  a_load_starts_run: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> busy && !done)
    else $error("accepted request did not start a search");

endmodule

/* sv/nes7_dp.sv */
module nes7_dp #(
  parameter int unsigned WIDTH = 24
) (
  input  logic                       clk,
  input  nes7_pkg::nes7_cmd_t        cmd,
  input  logic [nes7_pkg::IO_W-1:0]  request_size,
  output nes7_pkg::nes7_status_t     status,
  output logic [nes7_pkg::IO_W-1:0]  chosen_size
);
  import nes7_pkg::*;

  localparam int unsigned CW = (WIDTH + 1 > IO_W) ? WIDTH + 1 : IO_W;
  localparam logic [CW-1:0] LIMIT = CW'(64'd1 << WIDTH);
  localparam logic [CW-1:0] THR3 = CW'(((64'd1 << CW) - 64'd1) / 64'd3);
  localparam logic [CW-1:0] THR5 = CW'(((64'd1 << CW) - 64'd1) / 64'd5);
  localparam logic [CW-1:0] THR7 = CW'(((64'd1 << CW) - 64'd1) / 64'd7);

  logic [CW-1:0]   cand;
  logic [CW-1:0]   val;
  logic [1:0]      sel;
  logic [CW-1:0]   req_ext;
  logic [CW-1:0]   req_sat;
  logic [CW-1:0]   start_cand;
  logic [CW-1:0]   cand_plus;
  logic [CW-1:0]   inv;
  logic [CW-1:0]   thr;
  logic [CW-1:0]   prod;
  logic [CW-1:0]   quot;
  logic            divisible;

  // exact division by odd constants via the modular inverse, by 2 via a shift
  always_comb begin
    case (sel)
      DIV3:    begin inv = INV3[CW-1:0]; thr = THR3; end
      DIV5:    begin inv = INV5[CW-1:0]; thr = THR5; end
      DIV7:    begin inv = INV7[CW-1:0]; thr = THR7; end
      default: begin inv = INV3[CW-1:0]; thr = THR3; end
    endcase
    prod = val * inv;
    if (sel == DIV2) begin
      divisible = ~val[0];
      quot      = val >> 1;
    end else begin
      divisible = (prod <= thr);
      quot      = prod;
    end
  end

  assign req_ext    = CW'(request_size);
  assign req_sat    = (req_ext > LIMIT) ? LIMIT : req_ext;
  assign start_cand = req_sat + CW'(req_sat[0]);
  assign cand_plus  = cand + CW'(2);

  assign status.smooth = (val <= CW'(1)) || (cand >= LIMIT);
  assign status.fail   = !divisible && (sel == DIV7);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand <= start_cand;
      val  <= start_cand;
      sel  <= DIV2;
    end else if (cmd.next) begin
      cand <= cand_plus;
      val  <= cand_plus;
      sel  <= DIV2;
    end else if (cmd.step) begin
      if (divisible) begin
        val <= quot;
      end else begin
        sel <= sel + 2'd1;
      end
    end
    if (cmd.finish) begin
      chosen_size <= cand[IO_W-1:0];
    end
  end

endmodule

/* dv/tb_next_even_7_smooth_number.sv */
module tb_next_even_7_smooth_number;
  timeunit 1ns;
  timeprecision 1ps;

  import nes7_pkg::*;

  localparam int unsigned SIZE_BITS = 24;
  localparam int unsigned SIZE_LIMIT = 1 << SIZE_BITS;
  localparam int unsigned ITEMS_PER_PHASE = 500;
  localparam longint unsigned CYCLE_LIMIT = 20_000_000;
  localparam int unsigned DRAIN_CYCLES = 16;

  typedef logic [IO_W-1:0] size_t;

  class size_scoreboard;
    size_t expected_q[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned requests_seen;

    function bit is_7_smooth(int unsigned v);
      int unsigned r;
      r = v;
      if (r <= 1) return 1'b1;
      while (r != 1) begin
        if (r % 2 == 0) r = r / 2;
        else if (r % 3 == 0) r = r / 3;
        else if (r % 5 == 0) r = r / 5;
        else if (r % 7 == 0) r = r / 7;
        else return 1'b0;
      end
      return 1'b1;
    endfunction

    function size_t next_even_smooth(size_t req);
      int unsigned cand;
      cand = 32'(req);
      if (cand > SIZE_LIMIT) cand = SIZE_LIMIT;
      if (cand[0]) cand = cand + 1;
      while (cand < SIZE_LIMIT && !is_7_smooth(cand)) cand = cand + 2;
      return cand[IO_W-1:0];
    endfunction

    function void report(string what, size_t want, size_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %0d: %s expected %0d got %0d", mismatches, what, want, got);
    endfunction

    function void note_request(size_t req);
      requests_seen++;
      expected_q.push_back(next_even_smooth(req));
    endfunction

    function void check_result(size_t got);
      size_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("chosen_size with no request outstanding", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) report("chosen_size", want, got);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  size_t request_size = '0;
  logic busy;
  logic done;
  size_t chosen_size;

  size_scoreboard sb;
  longint unsigned cycles = 0;
  int unsigned large_sent = 0;

  next_even_7_smooth_number #(
    .WIDTH(SIZE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request_size(request_size),
    .done(done),
    .chosen_size(chosen_size)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("FAIL next_even_7_smooth_number");
      $finish;
    end
  end

  // result first so a same-edge transfer in does not jump the queue
  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) sb.check_result(chosen_size);
      if (start && busy === 1'b0) sb.note_request(request_size);
    end
  end

  task automatic send_request(size_t req, int unsigned idle_pct);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request_size <= req;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic wait_all_results();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic size_t random_request();
    int unsigned pick;
    int unsigned bits;
    size_t v;
    pick = $urandom_range(999);
    if (pick < 3) begin
      large_sent++;
      v = size_t'($urandom);
    end else begin
      if (pick < 40) bits = $urandom_range(15, 18);
      else bits = $urandom_range(1, 13);
      v = size_t'($urandom & ((1 << bits) - 1));
    end
    return v;
  endfunction

  initial begin
    size_t directed[$];
    int unsigned phase_idle[4];
    sb = new();
    directed = '{25'd0, 25'd1, 25'd2, 25'd3, 25'd4, 25'd5, 25'd7, 25'd8, 25'd11, 25'd13,
                 25'd17, 25'd97, 25'd1023, 25'd1024, 25'd1025, 25'd8388608,
                 25'd16777214, 25'd16777215, 25'd16777216, 25'd16777217,
                 25'h1555555, 25'h1FFFFFF};
    phase_idle = '{0, 62, 0, 30};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_request(directed[i], 0);

    foreach (phase_idle[p]) begin
      // hold off between phases until every result is back
      start <= 1'b0;
      @(posedge clk);
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clk);
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++)
        send_request(random_request(), phase_idle[p]);
    end

    start <= 1'b0;
    @(posedge clk);
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests checked (%0d directed at edges and range limit, %0d random large)",
             sb.requests_seen, directed.size(), large_sent);
    $display("idle phases none, sender 62%%, none, sender 30%%; %0d results, %0d cycles",
             sb.results_seen, cycles);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS next_even_7_smooth_number");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("FAIL next_even_7_smooth_number");
    end
    $finish;
  end
endmodule
